>>> hdl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam int CAPACITY = 1024;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;

  localparam logic signed [DATA_W-1:0] NO_WORD = -32'sd1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     underflow;
    logic                     overflow;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
  } res_t;

endpackage

>>> hdl/double_ended_queue.sv
`timescale 1ns / 1ps
// path: an accepted item goes through the first stage into the output register
// throughput: 1 item per cycle while res_stall is low; set by the two registered
// read ports of the ring store, which refresh the cached front and back words
// every cycle
// reset: synchronous, clears head, count and both valid stages and sets tail to
// the last slot; the ring store itself is not cleared and needs no clearing pass
module double_ended_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  deq_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output deq_pkg::res_t res
);
  import deq_pkg::*;

  // ring pointers: tail is always head + count - 1 modulo the capacity,
  // so it sits just before head when the queue is empty
  logic [ADDR_W-1:0] head, head_next;
  logic [ADDR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0]  count, count_next;

  // ring store with one write port and two registered read ports
  logic [DATA_W-1:0] mem [CAPACITY];
  logic              wen;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] rd_front, rd_back;
  logic              hit_front, hit_back;
  logic [DATA_W-1:0] wdata_q;
  logic signed [DATA_W-1:0] front_q, back_q;

  // first stage: flags and count of the item, waiting for its front and back words
  logic                     a_valid;
  logic signed [DATA_W-1:0] a_popped;
  logic                     a_under;
  logic                     a_over;
  logic [CNT_W-1:0]         a_count;
  logic                     a_empty;

  logic                     accept;
  logic                     out_free;
  logic                     full, empty;
  logic signed [DATA_W-1:0] popped;
  logic                     under, over;

  function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(CAPACITY - 1)) ? '0 : p + ADDR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] p);
    return (p == '0) ? ADDR_W'(CAPACITY - 1) : p - ADDR_W'(1);
  endfunction

  // output register is free when empty or being taken this cycle
  assign out_free  = !res_valid || !res_stall;
  // hold off only while the first stage cannot move on
  assign cmd_stall = a_valid && !out_free;
  assign accept    = cmd_valid && !cmd_stall;

  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);

  // cached words, with a write made at the same edge as their read forwarded
  assign front_q = hit_front ? wdata_q : rd_front;
  assign back_q  = hit_back  ? wdata_q : rd_back;

  // one operation: pointer step, one store write, popped word from the cache
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    wen        = 1'b0;
    waddr      = head;
    popped     = NO_WORD;
    under      = 1'b0;
    over       = 1'b0;
    if (accept) begin
      unique case (cmd.operation)
        OP_PUSH_FRONT: begin
          if (full) begin
            over = 1'b1;
          end else begin
            head_next  = ring_dec(head);
            waddr      = head_next;
            wen        = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            over = 1'b1;
          end else begin
            tail_next  = ring_inc(tail);
            waddr      = tail_next;
            wen        = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            under = 1'b1;
          end else begin
            popped     = front_q;
            head_next  = ring_inc(head);
            count_next = count - CNT_W'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            under = 1'b1;
          end else begin
            popped     = back_q;
            tail_next  = ring_dec(tail);
            count_next = count - CNT_W'(1);
          end
        end
        default: begin
          // query and unused codes leave the state alone
        end
      endcase
    end
  end

  // store: reads follow the pointers as they stand after this edge
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= cmd.push_value;
    end
    rd_front  <= mem[head_next];
    rd_back   <= mem[tail_next];
    hit_front <= wen && (waddr == head_next);
    hit_back  <= wen && (waddr == tail_next);
    wdata_q   <= cmd.push_value;
  end

  // pointer and count state
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= ADDR_W'(CAPACITY - 1);
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (out_free) begin
      a_valid <= 1'b0;
    end
    if (accept) begin
      a_popped <= popped;
      a_under  <= under;
      a_over   <= over;
      a_count  <= count_next;
      a_empty  <= (count_next == '0);
    end
  end

  // output register: front and back words join the item here, since the
  // cache always matches the state left by the item in the first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= a_valid;
    end
    if (out_free && a_valid) begin
      res.popped_value <= a_popped;
      res.underflow    <= a_under;
      res.overflow     <= a_over;
      res.entry_count  <= a_count;
      res.is_empty     <= a_empty;
      res.front_value  <= a_empty ? NO_WORD : front_q;
      res.back_value   <= a_empty ? NO_WORD : back_q;
    end
  end

  // count never passes the capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a stall only comes from both stages being full and the output held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (a_valid && res_valid && res_stall))
    else $error("input stalled without a full pipeline");

  // a pop on an empty queue is flagged in the first stage
  a_underflow: assert property (@(posedge clk) disable iff (rst)
    (accept && empty && (cmd.operation == OP_POP_FRONT ||
                         cmd.operation == OP_POP_BACK)) |=> a_under)
    else $error("missed underflow");

  // state moves only with an accepted item
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(count) && $stable(head) && $stable(tail)))
    else $error("state changed without an item");

endmodule
